// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define DWMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwma: same-cycle check failed");

// next-cycle implication, clocked on clk, off during rst
`define DWMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwma: next-cycle check failed");

`endif

// ----- rtl/core/dwma_pkg.sv -----
// Package: constants, codes and control types of the double weighted moving average core
`default_nettype none

package dwma_pkg;

  localparam int DEF_MAX_PERIOD  = 256;
  localparam int DEF_SAMPLE_BITS = 32;

  localparam int RECIP_BITS    = 33;
  localparam int SCALE_SHIFT   = 32;
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 4;
  localparam int REG_SEL_BIT   = 3;

  localparam logic [RECIP_BITS-1:0] RECIP_ONE = 33'h1_0000_0000;

  typedef enum logic [0:0] {
    REG_PERIOD = 1'b0,
    REG_RECIP  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_ACC1,
    ST_SLO1,
    ST_SHI1,
    ST_FIN1,
    ST_MUL2,
    ST_ACC2,
    ST_SLO2,
    ST_SHI2,
    ST_FIN2
  } state_t;

  typedef enum logic [2:0] {
    MUL_WT1,
    MUL_RLO1,
    MUL_RHI1,
    MUL_WT2,
    MUL_RLO2,
    MUL_RHI2
  } mul_sel_t;

  typedef struct packed {
    logic     load_x;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc1;
    logic     fin1;
    logic     swr;
    logic     acc2;
    logic     fin2;
    logic     count_up;
    logic     pwp_up;
    logic     swp_up;
  } cmd_t;

  typedef struct packed {
    logic warm1;
    logic warm2;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/dwma_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module dwma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dwma_regs.sv -----
// Configuration registers behind the APB-style port
`default_nettype none

module dwma_regs #(
  parameter int MAX_PERIOD = dwma_pkg::DEF_MAX_PERIOD,
  localparam int PW = $clog2(MAX_PERIOD + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dwma_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [dwma_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [dwma_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  output logic      [PW-1:0]                      period,
  output logic      [dwma_pkg::RECIP_BITS-1:0]    recip,
  output logic                                    restart
);

  import dwma_pkg::*;

  reg_idx_t              idx;
  logic                  wr;
  logic [PW-1:0]         period_wr;
  logic [RECIP_BITS-1:0] recip_wr;

  assign idx     = reg_idx_t'(paddr[REG_SEL_BIT]);
  assign wr      = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign restart = wr && (idx == REG_PERIOD);

  always_comb begin
    if (pwdata == '0) begin
      period_wr = PW'(1);
    end else if (pwdata > APB_DATA_BITS'(MAX_PERIOD)) begin
      period_wr = PW'(MAX_PERIOD);
    end else begin
      period_wr = pwdata[PW-1:0];
    end
    if (pwdata[RECIP_BITS-1:0] > RECIP_ONE) begin
      recip_wr = RECIP_ONE;
    end else begin
      recip_wr = pwdata[RECIP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PW'(1);
      recip  <= RECIP_ONE;
    end else if (wr) begin
      case (idx)
        REG_PERIOD: period <= period_wr;
        REG_RECIP:  recip  <= recip_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD: prdata = APB_DATA_BITS'(period);
      REG_RECIP:  prdata = APB_DATA_BITS'(recip);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/dwma_ctrl.sv -----
// Controller state machine: sequences both averaging stages and owns the output valid
`default_nettype none

module dwma_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire dwma_pkg::sts_t sts,
  output dwma_pkg::cmd_t      cmd
);

  import dwma_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_blocked;

  assign out_blocked    = out_valid & ~out_ready;
  assign out_valid_next = cmd.fin2 | out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = MUL_WT1;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WT1;
        state_next  = ST_ACC1;
      end
      ST_ACC1: begin
        cmd.acc1 = 1'b1;
        if (sts.warm1) begin
          cmd.count_up = 1'b1;
          cmd.pwp_up   = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_SLO1;
        end
      end
      ST_SLO1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RLO1;
        state_next  = ST_SHI1;
      end
      ST_SHI1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RHI1;
        state_next  = ST_FIN1;
      end
      ST_FIN1: begin
        cmd.fin1   = 1'b1;
        cmd.pwp_up = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WT2;
        cmd.swr     = 1'b1;
        state_next  = ST_ACC2;
      end
      ST_ACC2: begin
        cmd.acc2 = 1'b1;
        if (sts.warm2) begin
          cmd.count_up = 1'b1;
          cmd.swp_up   = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_SLO2;
        end
      end
      ST_SLO2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RLO2;
        state_next  = ST_SHI2;
      end
      ST_SHI2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RHI2;
        state_next  = ST_FIN2;
      end
      ST_FIN2: begin
        if (!out_blocked) begin
          cmd.fin2   = 1'b1;
          cmd.swp_up = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/dwma_dp.sv -----
// Datapath: accumulators, rings, shared multiplier and reciprocal scaling
`default_nettype none

module dwma_dp #(
  parameter int MAX_PERIOD  = dwma_pkg::DEF_MAX_PERIOD,
  parameter int SAMPLE_BITS = dwma_pkg::DEF_SAMPLE_BITS,
  localparam int PW = $clog2(MAX_PERIOD + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            restart,
  input  wire logic        [PW-1:0]            period,
  input  wire logic        [dwma_pkg::RECIP_BITS-1:0] recip,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample,
  input  wire dwma_pkg::cmd_t                  cmd,
  output dwma_pkg::sts_t                       sts,
  output logic signed      [SAMPLE_BITS-1:0]   dwma_value
);

  import dwma_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int NUM  = SB + 16;
  localparam int SUMB = SB + 8;
  localparam int LO   = NUM / 2;
  localparam int HI   = NUM - LO;
  localparam int CW   = $clog2(2 * MAX_PERIOD);
  localparam int AW   = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int OW   = ((AW > PW) ? AW : PW) + 1;
  localparam int MA0  = (SB > HI) ? SB : HI;
  localparam int MA   = (MA0 > LO + 1) ? MA0 : LO + 1;
  localparam int MB   = (PW + 1 > RECIP_BITS + 1) ? PW + 1 : RECIP_BITS + 1;
  localparam int PB   = NUM + MB;
  localparam int QW   = PB - SCALE_SHIFT;

  logic signed [SB-1:0]      x_reg, f_reg;
  logic signed [NUM-1:0]     num1, num2, prod_num;
  logic signed [SUMB-1:0]    sum1, sum2;
  logic        [CW-1:0]      count;
  logic        [AW-1:0]      pwp, swp, p_old, s_old;
  logic        [SB-1:0]      p_rdata, s_rdata;
  logic signed [SB-1:0]      p_oldv, s_oldv;
  logic        [PW-1:0]      pm1, wt1, wt2;
  logic signed [MA-1:0]      mul_a;
  logic signed [MB-1:0]      mul_b;
  logic signed [MA+MB-1:0]   prod, plow;
  logic signed [PB-1:0]      pfull;
  logic signed [QW-1:0]      q;
  logic                      q_fits;
  logic signed [SB-1:0]      scaled;
  logic                      hi_sel;

  assign pm1       = period - PW'(1);
  assign sts.warm1 = count < CW'(pm1);
  assign sts.warm2 = count < (CW'(pm1) << 1);
  assign wt1       = sts.warm1 ? PW'(count + CW'(1)) : period;
  assign wt2       = sts.warm2 ? PW'(count - CW'(pm1) + CW'(1)) : period;

  assign p_old = (OW'(pwp) >= OW'(pm1)) ? AW'(OW'(pwp) - OW'(pm1))
                                        : AW'(OW'(pwp) + OW'(MAX_PERIOD) - OW'(pm1));
  assign s_old = (OW'(swp) >= OW'(pm1)) ? AW'(OW'(swp) - OW'(pm1))
                                        : AW'(OW'(swp) + OW'(MAX_PERIOD) - OW'(pm1));

  assign p_oldv = (pm1 == '0) ? x_reg : signed'(p_rdata);
  assign s_oldv = (pm1 == '0) ? f_reg : signed'(s_rdata);

  dwma_ram #(.WIDTH(SB), .DEPTH(MAX_PERIOD)) u_price_ring (
    .clk   (clk),
    .we    (cmd.load_x),
    .waddr (pwp),
    .wdata (sample),
    .raddr (p_old),
    .rdata (p_rdata)
  );

  dwma_ram #(.WIDTH(SB), .DEPTH(MAX_PERIOD)) u_smooth_ring (
    .clk   (clk),
    .we    (cmd.swr),
    .waddr (swp),
    .wdata (f_reg),
    .raddr (s_old),
    .rdata (s_rdata)
  );

  always_comb begin
    case (cmd.mul_sel)
      MUL_WT1: begin
        mul_a = MA'(x_reg);
        mul_b = MB'(wt1);
      end
      MUL_RLO1: begin
        mul_a = MA'({1'b0, num1[LO-1:0]});
        mul_b = MB'(recip);
      end
      MUL_RHI1: begin
        mul_a = MA'(signed'(num1[NUM-1:LO]));
        mul_b = MB'(recip);
      end
      MUL_WT2: begin
        mul_a = MA'(f_reg);
        mul_b = MB'(wt2);
      end
      MUL_RLO2: begin
        mul_a = MA'({1'b0, num2[LO-1:0]});
        mul_b = MB'(recip);
      end
      MUL_RHI2: begin
        mul_a = MA'(signed'(num2[NUM-1:LO]));
        mul_b = MB'(recip);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign hi_sel   = (cmd.mul_sel == MUL_RHI1) || (cmd.mul_sel == MUL_RHI2);
  assign prod_num = prod[NUM-1:0];

  // floor(num * recip / 2^32), saturated to the sample range
  assign pfull  = (PB'(prod) <<< LO) + PB'(plow);
  assign q      = pfull[PB-1:SCALE_SHIFT];
  assign q_fits = (&q[QW-1:SB-1]) || !(|q[QW-1:SB-1]);
  assign scaled = q_fits ? q[SB-1:0]
                         : (q[QW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_reg <= sample;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
      if (hi_sel) begin
        plow <= prod;
      end
    end
    if (cmd.fin1) begin
      f_reg <= scaled;
    end
    if (cmd.fin2) begin
      dwma_value <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      num1  <= '0;
      sum1  <= '0;
      num2  <= '0;
      sum2  <= '0;
      count <= '0;
      pwp   <= '0;
      swp   <= '0;
    end else begin
      if (cmd.acc1) begin
        num1 <= num1 + prod_num;
        sum1 <= sum1 + SUMB'(x_reg);
      end else if (cmd.fin1) begin
        num1 <= num1 - NUM'(sum1);
        sum1 <= sum1 - SUMB'(p_oldv);
      end
      if (cmd.acc2) begin
        num2 <= num2 + prod_num;
        sum2 <= sum2 + SUMB'(f_reg);
      end else if (cmd.fin2) begin
        num2 <= num2 - NUM'(sum2);
        sum2 <= sum2 - SUMB'(s_oldv);
      end
      if (cmd.count_up) begin
        count <= count + CW'(1);
      end
      if (cmd.pwp_up) begin
        pwp <= (pwp == AW'(MAX_PERIOD - 1)) ? '0 : pwp + AW'(1);
      end
      if (cmd.swp_up) begin
        swp <= (swp == AW'(MAX_PERIOD - 1)) ? '0 : swp + AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/double_weighted_moving_average_core.sv -----
// Double weighted moving average core: top level
//
// Input channel (in_valid/in_ready/sample) takes one signed Q16.16 word per
// accepted handshake; output channel (out_valid/out_ready/dwma_value) gives one
// signed Q16.16 word per sample once 2*(period-1) samples have warmed up.
// Registers over the APB-style port: period at 0x0, recip_denom at 0x8.
// Writing period restarts the stream; write config only while idle.
// One multiplier serves the weight products and both partial products of
// each reciprocal scale; a new sample is taken only once the last is done.
// In the first warm-up a sample is weighted and summed; in the second it is
// also scaled by stage one and summed by stage two; later both run in full.
// The output sits in a register: the next sample is taken while it waits.
// If the receiver stalls, the following result holds in its last step until
// the register drains; nothing is dropped.
// Reset (rst, synchronous) clears accumulators, counters and pointers and
// sets period to 1 and recip_denom to 1.0; ring contents are not cleared.
`default_nettype none

module double_weighted_moving_average_core #(
  parameter int MAX_PERIOD  = dwma_pkg::DEF_MAX_PERIOD,
  parameter int SAMPLE_BITS = dwma_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed      [SAMPLE_BITS-1:0]      dwma_value,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dwma_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [dwma_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [dwma_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready
);

  import dwma_pkg::*;

  `include "assert_macros.svh"

  localparam int PW = $clog2(MAX_PERIOD + 1);

  logic [PW-1:0]         period;
  logic [RECIP_BITS-1:0] recip;
  logic                  restart;
  cmd_t                  cmd;
  sts_t                  sts;

  dwma_regs #(.MAX_PERIOD(MAX_PERIOD)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .period  (period),
    .recip   (recip),
    .restart (restart)
  );

  dwma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dwma_dp #(.MAX_PERIOD(MAX_PERIOD), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .period     (period),
    .recip      (recip),
    .sample     (sample),
    .cmd        (cmd),
    .sts        (sts),
    .dwma_value (dwma_value)
  );

  `DWMA_ASSERT_NOW(a_no_overwrite, cmd.fin2, !(out_valid && !out_ready))
  `DWMA_ASSERT_NEXT(a_fin_gives_word, cmd.fin2, out_valid)
  `DWMA_ASSERT_NOW(a_valid_from_fin, $rose(out_valid), $past(cmd.fin2))
  `DWMA_ASSERT_NEXT(a_busy_after_take, cmd.load_x, !in_ready)

endmodule

`default_nettype wire
